// ===== hw/rtl/ebpg_pkg.sv =====
// Package for the endpoint backoff probe gate: widths, codes, reset values,
// the table entry layout and the controller/datapath command and status types.
// Depends on nothing; every other file of the block imports it.
package ebpg_pkg;

	localparam int ENDPOINTS = 64;
	localparam int EIW       = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

	localparam int TIME_W  = 48;
	localparam int REG_W   = 32;
	localparam int CNT_W   = 6;
	localparam int IDX_W   = 6;
	localparam int HINT_W  = 16;
	localparam int HMS_W   = 26;
	localparam int KIND_W  = 3;
	localparam int CIDX_W  = 8;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 56;

	localparam logic [CNT_W-1:0]  COUNT_MAX  = 6'd63;
	localparam logic [9:0]        HINT_SCALE = 10'd1000;
	localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

	localparam logic [REG_W-1:0] INITIAL_DELAY_RST = 32'd1000;
	localparam logic [REG_W-1:0] MAX_DELAY_RST     = 32'd300000;
	localparam logic [REG_W-1:0] PROBE_POLL_RST    = 32'd1000;

	typedef enum logic [CIDX_W-1:0] {
		REG_INITIAL_DELAY = 8'd0,
		REG_MAX_DELAY     = 8'd1,
		REG_PROBE_POLL    = 8'd2
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		K_ACQUIRE = 3'd0,
		K_FAILURE = 3'd1,
		K_SUCCESS = 3'd2,
		K_RELEASE = 3'd3,
		K_RESET   = 3'd4
	} kind_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic              busy;
		logic [TIME_W-1:0] not_before;
	} entry_t;

	typedef struct packed {
		logic load;
		logic read;
		logic eval;
		logic step;
		logic delay;
		logic write;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic iter_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/endpoint_backoff_probe_gate.sv =====
// Top level of the endpoint backoff probe gate: circuit breaker with exponential
// backoff and a single recovery probe per endpoint. Depends on ebpg_pkg,
// ebpg_ctrl and ebpg_datapath.
//
//   Channel  Direction  Handshake                    Word
//   s_axis   in         s_axis_tvalid/s_axis_tready  one operation on one endpoint
//   m_axis   out        m_axis_tvalid/m_axis_tready  one result per operation
//   cfg      in         cfg_valid/cfg_ready          one register write
//
// After acceptance an operation passes the read, eval, step, delay, write and emit
// states; the shared doubling step runs one iteration per cycle, counting down from
// n - 1, where n is the failure count fed to it (n = 0 or 1 when no backoff is due).
// Reset clears every table entry at once through per-entry valid bits; no sweep.
// A result waiting in the output register does not block the next word on s_axis;
// only its own result waits for the register to drain. cfg is always ready.
module endpoint_backoff_probe_gate
	import ebpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// endpoint_index[5:0], now_ms[53:6], owns_probe[54], has_hint[55],
	// hint_seconds[71:56]
	input  logic [IN_W-1:0]   s_axis_tdata,
	// kind[2:0]
	input  logic [KIND_W-1:0] s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// allowed[0], is_probe[1], retry_after_ms[49:2], zero fill[55:50]
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Configuration writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences read, decide, backoff, write and emit.
	ebpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table, the registers and the output word.
	ebpg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef NO_ASSERTIONS
	// One word at a time: after acceptance the input side closes.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// A granted probe is always an allowed acquire.
	a_probe_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("probe granted without allow");

	// An allowed result carries no retry time.
	a_allow_no_retry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[49:2] == '0)
		else $error("allowed result with nonzero retry time");
`endif

endmodule

// ===== hw/rtl/ebpg_ctrl.sv =====
// Controller state machine of the endpoint backoff probe gate.
// Depends on ebpg_pkg for the command and status structs.
module ebpg_ctrl
	import ebpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_EVAL  = 7'b0000100,
		ST_STEP  = 7'b0001000,
		ST_DELAY = 7'b0010000,
		ST_WRITE = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				if (sts.iter_zero) begin
					state_d = ST_DELAY;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DELAY: begin
				cmd.delay = 1'b1;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ebpg_datapath.sv =====
// Datapath of the endpoint backoff probe gate: configuration registers, the
// endpoint table memory with its valid bits, the backoff unit and the output word.
// Depends on ebpg_pkg.
module ebpg_datapath
	import ebpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [IN_W-1:0]   in_data,
	input  logic [KIND_W-1:0] in_kind,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  out_data,
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [REG_W-1:0] initial_delay_q, max_delay_q, probe_poll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q <= INITIAL_DELAY_RST;
			max_delay_q     <= MAX_DELAY_RST;
			probe_poll_q    <= PROBE_POLL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INITIAL_DELAY: initial_delay_q <= cfg_data;
				REG_MAX_DELAY:     max_delay_q     <= cfg_data;
				REG_PROBE_POLL:    probe_poll_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured input word.
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic              owns_q, hinted_q;
	logic [HINT_W-1:0] hint_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			idx_q    <= in_data[5:0];
			now_q    <= in_data[53:6];
			owns_q   <= in_data[54];
			hinted_q <= in_data[55];
			hint_q   <= in_data[71:56];
		end
	end

	logic [EIW-1:0] addr;
	logic           idx_ok;
	assign addr   = EIW'(idx_q);
	assign idx_ok = ({26'd0, idx_q} < ENDPOINTS);

	// Endpoint table: entries without a valid bit read as cleared.
	entry_t             mem_q [ENDPOINTS];
	logic [ENDPOINTS-1:0] vld_q;
	entry_t             rd_ent_q;
	logic               rd_vld_q, ok_q;
	logic [HMS_W-1:0]   hint_ms_q;

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_ent_q  <= mem_q[addr];
			hint_ms_q <= HMS_W'(hint_q * HINT_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			ok_q     <= 1'b0;
		end else if (cmd.read) begin
			rd_vld_q <= idx_ok & vld_q[addr];
			ok_q     <= idx_ok;
		end
	end

	// Decision for the item, from the entry as read.
	entry_t            cur, ent_d;
	logic              allow_d, probe_d, wr_d, clr_d, bo_d, lt;
	logic [TIME_W-1:0] retry_d;

	always_comb begin
		cur     = rd_vld_q ? rd_ent_q : '0;
		ent_d   = cur;
		allow_d = 1'b0;
		probe_d = 1'b0;
		retry_d = '0;
		wr_d    = 1'b0;
		clr_d   = 1'b0;
		bo_d    = 1'b0;
		lt      = now_q < cur.not_before;
		unique case (kind_q)
			K_ACQUIRE: begin
				if (!rd_vld_q) begin
					allow_d = 1'b1;
				end else if (lt) begin
					retry_d = cur.not_before - now_q;
				end else if (cur.busy) begin
					retry_d = TIME_W'(probe_poll_q);
				end else begin
					ent_d.busy = 1'b1;
					wr_d       = 1'b1;
					allow_d    = 1'b1;
					probe_d    = 1'b1;
				end
			end
			K_FAILURE: begin
				if (ok_q) begin
					wr_d = 1'b1;
					if (!rd_vld_q) begin
						ent_d       = '0;
						ent_d.count = CNT_W'(1);
						bo_d        = 1'b1;
					end else if (owns_q && cur.busy) begin
						if (cur.count != COUNT_MAX) begin
							ent_d.count = cur.count + CNT_W'(1);
						end
						ent_d.busy = 1'b0;
						bo_d       = 1'b1;
					end
				end
			end
			K_SUCCESS, K_RESET: begin
				clr_d = ok_q;
			end
			K_RELEASE: begin
				if (rd_vld_q) begin
					ent_d.busy = 1'b0;
					wr_d       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	entry_t            ent_q;
	logic              allow_q, probe_q, wr_q, clr_q, bo_q;
	logic [TIME_W-1:0] retry_q;
	logic [CNT_W-1:0]  iter_q;
	logic [REG_W-1:0]  d_q, delay_q;

	logic [REG_W:0]   dbl;
	logic [REG_W-1:0] dmin, dsel;
	assign dbl  = {d_q, 1'b0};
	assign dmin = (d_q > max_delay_q) ? max_delay_q : d_q;

	always_comb begin
		if (bo_q) begin
			dsel = (hinted_q && REG_W'(hint_ms_q) > dmin) ? REG_W'(hint_ms_q) : dmin;
		end else begin
			dsel = hinted_q ? REG_W'(hint_ms_q) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			ent_q   <= ent_d;
			allow_q <= allow_d;
			probe_q <= probe_d;
			retry_q <= retry_d;
			bo_q    <= bo_d;
			d_q     <= initial_delay_q;
		end
		if (cmd.delay) begin
			delay_q <= dsel;
		end
		if (cmd.step) begin
			d_q <= (dbl > {1'b0, max_delay_q}) ? max_delay_q : dbl[REG_W-1:0];
		end
	end

	// Iteration count and write strobes carry reset: they steer the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			wr_q   <= 1'b0;
			clr_q  <= 1'b0;
		end else if (cmd.eval) begin
			iter_q <= bo_d ? ent_d.count - CNT_W'(1) : '0;
			wr_q   <= wr_d;
			clr_q  <= clr_d;
		end else if (cmd.step) begin
			iter_q <= iter_q - CNT_W'(1);
		end
	end

	// Table write: saturating now plus delay, or a hint on a failure that only
	// pushes later.
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] tsat, nb_new;
	entry_t            wr_ent;

	assign sum  = {1'b0, now_q} + {{(TIME_W+1-REG_W){1'b0}}, delay_q};
	assign tsat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

	always_comb begin
		if (bo_q) begin
			nb_new = tsat;
		end else if (kind_q == K_FAILURE && hinted_q && tsat > ent_q.not_before) begin
			nb_new = tsat;
		end else begin
			nb_new = ent_q.not_before;
		end
		wr_ent            = ent_q;
		wr_ent.not_before = nb_new;
	end

	always_ff @(posedge clk) begin
		if (cmd.write && wr_q) begin
			mem_q[addr] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.write) begin
			if (wr_q) begin
				vld_q[addr] <= 1'b1;
			end else if (clr_q) begin
				vld_q[addr] <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data <= {6'd0, retry_q, probe_q, allow_q};
		end
	end

	assign sts.iter_zero = (iter_q == '0);
	assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for endpoint_backoff_probe_gate. It sends operation words, writes the
// delay registers and applies back-pressure, and checks each result word against a
// predictor kept in a scoreboard class. Depends on ebpg_pkg and the block's top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ebpg_pkg::*;

	// Kind codes the block must ignore, and register indexes it must ignore.
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;
	localparam logic [CIDX_W-1:0] REG_SPARE    = 8'd3;
	localparam logic [CIDX_W-1:0] REG_TOP      = 8'hFF;

	// Cycles without any word moved on any channel before the run is abandoned.
	// The slowest legitimate gap is a source gap, a full-length doubling loop and a
	// sink stall in a row, or the pause ahead of a register write.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int PHASE_OPS      = 225;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] now;
		logic              owns;
		logic              hinted;
		logic [HINT_W-1:0] hint_s;
	} gate_op_t;

	typedef struct {
		logic              allowed;
		logic              probe;
		logic [TIME_W-1:0] retry;
	} verdict_t;

	// Scoreboard: a copy of the endpoint table and the delay registers, updated as
	// each operation word is accepted, plus the verdicts still owed by the block.
	class backoff_gate_model;
		logic [REG_W-1:0]  init_delay;
		logic [REG_W-1:0]  cap_delay;
		logic [REG_W-1:0]  poll_delay;
		logic              present [ENDPOINTS];
		logic [CNT_W-1:0]  fails [ENDPOINTS];
		logic              probing [ENDPOINTS];
		logic [TIME_W-1:0] not_before [ENDPOINTS];
		verdict_t          verdicts_due [$];
		int                mismatches;

		function new();
			int e;
			init_delay = INITIAL_DELAY_RST;
			cap_delay  = MAX_DELAY_RST;
			poll_delay = PROBE_POLL_RST;
			for (e = 0; e < ENDPOINTS; e++)
				clear_entry(e);
			mismatches = 0;
		endfunction

		function void clear_entry(int e);
			present[e]    = 1'b0;
			fails[e]      = '0;
			probing[e]    = 1'b0;
			not_before[e] = '0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				REG_INITIAL_DELAY: init_delay = val;
				REG_MAX_DELAY:     cap_delay  = val;
				REG_PROBE_POLL:    poll_delay = val;
				default: ;
			endcase
		endfunction

		function logic [TIME_W-1:0] time_plus(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
			logic [TIME_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
		endfunction

		// Doubling backoff for failure count n, capped after every step and at the end.
		function logic [TIME_W-1:0] backoff(logic [CNT_W-1:0] n);
			logic [63:0] d;
			int i;
			if (n == 0)
				return '0;
			d = 64'(init_delay);
			for (i = 1; i < n; i++) begin
				d = d << 1;
				if (d > 64'(cap_delay))
					d = 64'(cap_delay);
			end
			if (d > 64'(cap_delay))
				d = 64'(cap_delay);
			return d[TIME_W-1:0];
		endfunction

		function void take_op(gate_op_t op);
			verdict_t v;
			int e;
			logic [TIME_W-1:0] hint_ms;
			logic [TIME_W-1:0] d;
			logic [TIME_W-1:0] t;
			logic fresh;
			logic lost_probe;
			v.allowed = 1'b0;
			v.probe   = 1'b0;
			v.retry   = '0;
			e = op.idx;
			hint_ms = 48'(op.hint_s) * 48'd1000;
			case (op.kind)
				K_ACQUIRE: begin
					if (!present[e]) begin
						v.allowed = 1'b1;
					end else if (op.now < not_before[e]) begin
						v.retry = not_before[e] - op.now;
					end else if (probing[e]) begin
						v.retry = 48'(poll_delay);
					end else begin
						probing[e] = 1'b1;
						v.allowed  = 1'b1;
						v.probe    = 1'b1;
					end
				end
				K_FAILURE: begin
					fresh      = !present[e];
					lost_probe = op.owns && !fresh && probing[e];
					if (fresh) begin
						clear_entry(e);
						present[e] = 1'b1;
						fails[e]   = 6'd1;
					end else if (lost_probe) begin
						if (fails[e] != COUNT_MAX)
							fails[e]++;
						probing[e] = 1'b0;
					end
					if (fresh || lost_probe) begin
						d = backoff(fails[e]);
						if (op.hinted && hint_ms > d)
							d = hint_ms;
						not_before[e] = time_plus(op.now, d);
					end else if (op.hinted) begin
						// Without a new backoff the hint can only push the deadline out.
						t = time_plus(op.now, hint_ms);
						if (t > not_before[e])
							not_before[e] = t;
					end
				end
				K_SUCCESS, K_RESET: clear_entry(e);
				K_RELEASE: begin
					if (present[e])
						probing[e] = 1'b0;
				end
				default: ;
			endcase
			verdicts_due.push_back(v);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		endfunction

		function void check_verdict(logic [OUT_W-1:0] word);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				$display("%0t: result word %h with no operation outstanding", $time, word);
				mismatches++;
				return;
			end
			want = verdicts_due.pop_front();
			if (word[0] !== want.allowed)
				report("allowed", 64'(want.allowed), 64'(word[0]));
			if (word[1] !== want.probe)
				report("is_probe", 64'(want.probe), 64'(word[1]));
			if (word[49:2] !== want.retry)
				report("retry_after_ms", 64'(want.retry), 64'(word[49:2]));
			if (word[OUT_W-1:50] !== '0)
				report("zero fill", 64'd0, 64'(word[OUT_W-1:50]));
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]  cfg_data = '0;

	backoff_gate_model gate = new();

	// Idle switches, redrawn every few dozen words so that stretches without any
	// gaps alternate with stretches where both sides hesitate at random.
	bit                src_idle_on = 1'b0;
	bit                sink_idle_on = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic [IDX_W-1:0]  hot [4];
	int                stall_cycles = 0;

	endpoint_backoff_probe_gate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drives one operation word and returns at the edge where it is taken. The
	// valid stays high between back-to-back words so it never toggles in one step.
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] now, input logic owns, input logic hinted,
			input logic [HINT_W-1:0] hint_s);
		int gap;
		gate_op_t op;
		gap = src_idle_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hint_s, hinted, owns, now, idx};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		op.kind   = kind;
		op.idx    = idx;
		op.now    = now;
		op.owns   = owns;
		op.hinted = hinted;
		op.hint_s = hint_s;
		gate.take_op(op);
	endtask

	task automatic write_word(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		gate.write_reg(idx, val);
	endtask

	// Writes all three delay registers back to back, optionally followed by writes
	// to indexes outside the register list, which the block must drop.
	task automatic program_regs(input logic [REG_W-1:0] first, input logic [REG_W-1:0] cap,
			input logic [REG_W-1:0] poll, input bit with_spare);
		write_word(REG_INITIAL_DELAY, first);
		write_word(REG_MAX_DELAY, cap);
		write_word(REG_PROBE_POLL, poll);
		if (with_spare) begin
			write_word(REG_SPARE, $urandom);
			write_word(REG_TOP, $urandom);
		end
		cfg_valid <= 1'b0;
	endtask

	// Registers change only once every verdict is in and the block has had time
	// to drain its longest doubling loop.
	task automatic settle();
		while (gate.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] any_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [TIME_W-1:0] later_than(logic [TIME_W-1:0] nb);
		logic [TIME_W-1:0] off;
		off = 48'($urandom_range(0, 50));
		return (nb > TIME_MAX - off) ? TIME_MAX : nb + off;
	endfunction

	function automatic logic [TIME_W-1:0] earlier_than(logic [TIME_W-1:0] nb);
		logic [TIME_W-1:0] off;
		off = 48'($urandom_range(1, 100000));
		if (off > nb)
			off = nb;
		return nb - off;
	endfunction

	// Mostly short hints, so the doubling backoff usually wins, with some of the
	// full range and the largest hint thrown in.
	function automatic logic [HINT_W-1:0] draw_hint();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return 16'($urandom_range(0, 20));
		else if (roll < 9)
			return 16'($urandom);
		return 16'hFFFF;
	endfunction

	// Opening sequence on the reset register values: every kind, the field
	// extremes, refusal for time down to one millisecond, refusal while a probe is
	// out, hint extension, owned probe failure, time saturation and spare kinds.
	task automatic directed_ops();
		send_op(K_ACQUIRE, 6'd0, 48'd0, 1'b0, 1'b0, 16'd0);
		send_op(K_FAILURE, 6'd0, 48'd1000, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd1500, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd1999, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd2000, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd2001, 1'b0, 1'b0, 16'd0);
		send_op(K_FAILURE, 6'd0, 48'd2100, 1'b0, 1'b1, 16'd10);
		send_op(K_FAILURE, 6'd0, 48'd2200, 1'b1, 1'b1, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd4200, 1'b0, 1'b0, 16'd0);
		send_op(K_RELEASE, 6'd0, 48'd4250, 1'b1, 1'b1, 16'hFFFF);
		send_op(K_RELEASE, 6'd5, 48'd4260, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, 48'd4300, 1'b0, 1'b0, 16'd0);
		send_op(K_FAILURE, 6'd0, TIME_MAX - 48'd5, 1'b1, 1'b1, 16'hFFFF);
		send_op(K_ACQUIRE, 6'd0, 48'd0, 1'b0, 1'b0, 16'd0);
		send_op(K_ACQUIRE, 6'd0, TIME_MAX, 1'b1, 1'b1, 16'hFFFF);
		send_op(K_SUCCESS, 6'd0, TIME_MAX, 1'b1, 1'b1, 16'hFFFF);
		send_op(K_ACQUIRE, 6'd0, TIME_MAX, 1'b0, 1'b0, 16'd0);
		send_op(K_FAILURE, 6'd63, 48'd0, 1'b0, 1'b1, 16'hFFFF);
		send_op(K_RESET, 6'd63, 48'd0, 1'b0, 1'b0, 16'd0);
		send_op(KIND_SPARE_A, 6'd63, TIME_MAX, 1'b1, 1'b1, 16'hFFFF);
		send_op(KIND_SPARE_B, 6'd63, TIME_MAX, 1'b1, 1'b1, 16'hFFFF);
		send_op(KIND_SPARE_C, 6'd63, TIME_MAX, 1'b1, 1'b1, 16'hFFFF);
		// An owned failure on an absent entry just creates it.
		send_op(K_FAILURE, 6'd1, 48'd500, 1'b1, 1'b0, 16'd0);
		send_op(K_FAILURE, 6'd1, 48'd600, 1'b0, 1'b1, 16'd3);
		send_op(K_SUCCESS, 6'd1, 48'd700, 1'b0, 1'b0, 16'd0);
	endtask

	// Repeated grant and owned failure on one endpoint, long enough to drive its
	// failure count into saturation and the doubling loop to full length.
	task automatic hammer(input logic [IDX_W-1:0] e, input int rounds);
		int r;
		send_op(K_FAILURE, e, clock_ms, 1'b0, 1'b0, 16'd0);
		for (r = 0; r < rounds; r++) begin
			send_op(K_ACQUIRE, e, later_than(gate.not_before[e]), 1'($urandom),
				1'($urandom), 16'($urandom));
			send_op(K_FAILURE, e, later_than(gate.not_before[e]), 1'b1,
				$urandom_range(0, 3) == 0, draw_hint());
		end
	endtask

	// One random operation, chosen from the state of the endpoint so that most
	// words follow the failure / grant / owned-failure life cycle, the rest being
	// early or late acquires, releases, clears and plain noise.
	task automatic random_op();
		logic [IDX_W-1:0]  e;
		logic [TIME_W-1:0] nb;
		logic [TIME_W-1:0] early;
		logic              hinted;
		logic [HINT_W-1:0] hint_s;
		int roll;
		e      = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)] : 6'($urandom);
		nb     = gate.not_before[e];
		early  = (nb != 0) ? earlier_than(nb) : clock_ms;
		hinted = $urandom_range(0, 2) == 0;
		hint_s = draw_hint();
		roll   = $urandom_range(0, 99);
		clock_ms = gate.time_plus(clock_ms, 48'($urandom_range(0, 2000)));
		if (roll < 5) begin
			send_op(3'($urandom), e, any_time(), 1'($urandom), 1'($urandom), 16'($urandom));
		end else if (!gate.present[e]) begin
			if (roll < 65)
				send_op(K_FAILURE, e, clock_ms, 1'($urandom), hinted, hint_s);
			else if (roll < 90)
				send_op(K_ACQUIRE, e, clock_ms, 1'($urandom), hinted, hint_s);
			else if (roll < 94)
				send_op(K_RELEASE, e, clock_ms, 1'($urandom), hinted, hint_s);
			else if (roll < 97)
				send_op(K_SUCCESS, e, clock_ms, 1'($urandom), hinted, hint_s);
			else
				send_op(K_RESET, e, clock_ms, 1'($urandom), hinted, hint_s);
		end else if (gate.probing[e]) begin
			if (roll < 45)
				send_op(K_FAILURE, e, later_than(nb), 1'b1, hinted, hint_s);
			else if (roll < 60)
				send_op(K_ACQUIRE, e, later_than(nb), 1'($urandom), hinted, hint_s);
			else if (roll < 70)
				send_op(K_ACQUIRE, e, early, 1'($urandom), hinted, hint_s);
			else if (roll < 82)
				send_op(K_RELEASE, e, any_time(), 1'($urandom), hinted, hint_s);
			else if (roll < 88)
				send_op(K_SUCCESS, e, any_time(), 1'($urandom), hinted, hint_s);
			else if (roll < 92)
				send_op(K_RESET, e, any_time(), 1'($urandom), hinted, hint_s);
			else
				send_op(K_FAILURE, e, later_than(nb), 1'b0, 1'b1, hint_s);
		end else begin
			if (roll < 55)
				send_op(K_ACQUIRE, e, later_than(nb), 1'($urandom), hinted, hint_s);
			else if (roll < 72)
				send_op(K_ACQUIRE, e, early, 1'($urandom), hinted, hint_s);
			else if (roll < 85)
				send_op(K_FAILURE, e, early, 1'($urandom), hinted, hint_s);
			else if (roll < 90)
				send_op(K_RELEASE, e, any_time(), 1'($urandom), hinted, hint_s);
			else if (roll < 95)
				send_op(K_SUCCESS, e, any_time(), 1'($urandom), hinted, hint_s);
			else
				send_op(K_RESET, e, any_time(), 1'($urandom), hinted, hint_s);
		end
	endtask

	// Sink side: hold ready low for a drawn number of cycles, then wait for the
	// next result word and check it.
	initial begin : result_sink
		int gap;
		forever begin
			gap = sink_idle_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			gate.check_verdict(m_axis_tdata);
		end
	end

	// Watchdog: any word on any channel restarts the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int p;
		int i;
		int h;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p < 7; p++) begin
			if (p > 0) begin
				settle();
				// Settings run from the reset values through both extremes, a cap
				// below the first delay, and random values.
				case (p)
					1: program_regs(32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
					2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
					3: program_regs(32'd0, 32'd0, 32'd0, 1'b0);
					4: program_regs(32'd5000, 32'd300, 32'd7, 1'b0);
					5: program_regs($urandom, 32'($urandom_range(0, 1 << 20)), $urandom, 1'b1);
					default: program_regs(INITIAL_DELAY_RST, MAX_DELAY_RST, PROBE_POLL_RST, 1'b1);
				endcase
			end
			for (h = 0; h < 4; h++)
				hot[h] = 6'($urandom);
			// One phase runs close to the top of the time range so that deadlines
			// saturate in the ordinary flow as well.
			clock_ms = (p == 2) ? TIME_MAX - 48'd50_000_000 : {16'd0, 32'($urandom)};
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			if (p == 0)
				directed_ops();
			if (p == 1 || p == 4)
				hammer(hot[0], 66);
			for (i = 0; i < PHASE_OPS; i++) begin
				if (i % 40 == 0) begin
					src_idle_on  = $urandom_range(0, 3) != 0;
					sink_idle_on = $urandom_range(0, 3) != 0;
				end
				random_op();
			end
			s_axis_tvalid <= 1'b0;
		end
		while (gate.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (gate.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
